// ----- rtl/core/dvbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dvbm_pkg;

	localparam int SLOT_BITS    = 16;
	localparam int NUM_DIST     = 11;
	localparam int ALWAYS_TERMS = 5;
	localparam int RESIDUES     = 5;
	localparam int TERM_W       = 4;
	localparam int PEN_W        = 11;
	localparam int SCORE_W      = 34;
	localparam int BEST_W       = 24;
	localparam int TAG_W        = 32;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 64;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [BEST_W-1:0] NO_BEST       = 24'd9999999;
	localparam logic [7:0]        PENALTY_RESET = 8'd40;

	// register index = paddr[4:3]
	localparam logic [1:0] REG_QUERY_NEAR = 2'd0;
	localparam logic [1:0] REG_QUERY_MID  = 2'd1;
	localparam logic [1:0] REG_QUERY_FAR  = 2'd2;
	localparam logic [1:0] REG_PENALTY    = 2'd3;

	typedef struct packed {
		logic [63:0] ref_near;
		logic [63:0] ref_mid;
		logic [47:0] ref_far;
		logic [4:0]  gly_pro_mask;
		logic [31:0] record_tag;
		logic        last_record;
	} rec_word_t;

	typedef struct packed {
		logic [SCORE_W-1:0] record_score;
		logic               new_best;
		logic [BEST_W-1:0]  best_score;
		logic [TAG_W-1:0]   best_tag;
		logic               search_done;
	} res_word_t;

	typedef struct packed {
		logic [63:0] query_near;
		logic [63:0] query_mid;
		logic [47:0] query_far;
		logic [7:0]  residue_penalty;
	} cfg_t;

	// classified record handed from front to back
	typedef struct packed {
		logic [NUM_DIST-1:0][SLOT_BITS-1:0] diff;
		logic [NUM_DIST-1:0]                used;
		logic [TERM_W-1:0]                  terms;
		logic [PEN_W-1:0]                   pen;
		logic [TAG_W-1:0]                   tag;
		logic                               last;
	} job_t;

endpackage

`default_nettype wire

// ----- rtl/core/dvbm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvbm_front import dvbm_pkg::*; #(
	parameter int DIST_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  rec_valid,
	output logic       rec_stall,
	input  wire rec_word_t rec_word,
	input  wire logic  full,
	output logic       push,
	output job_t       push_job
);

	localparam int DW = (DIST_BITS > SLOT_BITS) ? SLOT_BITS : DIST_BITS;
	localparam logic [SLOT_BITS-1:0] DMASK = SLOT_BITS'((32'd1 << DW) - 32'd1);

	logic [SLOT_BITS-1:0] q [NUM_DIST];
	logic [SLOT_BITS-1:0] r [NUM_DIST];
	job_t job_c;
	job_t job_s1;
	logic valid_s1;
	logic accept;
	logic [2:0] mask_cnt;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			q[k]     = cfg.query_near[k*SLOT_BITS +: SLOT_BITS] & DMASK;
			r[k]     = rec_word.ref_near[k*SLOT_BITS +: SLOT_BITS] & DMASK;
			q[4 + k] = cfg.query_mid[k*SLOT_BITS +: SLOT_BITS] & DMASK;
			r[4 + k] = rec_word.ref_mid[k*SLOT_BITS +: SLOT_BITS] & DMASK;
		end
		for (int k = 0; k < 3; k++) begin
			q[8 + k] = cfg.query_far[k*SLOT_BITS +: SLOT_BITS] & DMASK;
			r[8 + k] = rec_word.ref_far[k*SLOT_BITS +: SLOT_BITS] & DMASK;
		end
	end

	always_comb begin
		job_c.terms = TERM_W'(ALWAYS_TERMS);
		for (int k = 0; k < NUM_DIST; k++) begin
			job_c.diff[k] = (q[k] > r[k]) ? (q[k] - r[k]) : (r[k] - q[k]);
			if (k < ALWAYS_TERMS) begin
				job_c.used[k] = 1'b1;
			end else begin
				job_c.used[k] = (q[k] != '0);
				job_c.terms   = job_c.terms + TERM_W'(job_c.used[k]);
			end
		end
		mask_cnt = '0;
		for (int k = 0; k < RESIDUES; k++) begin
			mask_cnt = mask_cnt + 3'(rec_word.gly_pro_mask[k]);
		end
		job_c.pen  = PEN_W'(mask_cnt) * PEN_W'(cfg.residue_penalty);
		job_c.tag  = rec_word.record_tag;
		job_c.last = rec_word.last_record;
	end

	assign rec_stall = valid_s1 && full;
	assign accept    = rec_valid && !rec_stall;
	assign push      = valid_s1 && !full;
	assign push_job  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_c;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dvbm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvbm_queue import dvbm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dvbm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvbm_back import dvbm_pkg::*; #(
	parameter int DIST_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic empty,
	output logic      pop,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_word_t res_word
);

	localparam int DW     = (DIST_BITS > SLOT_BITS) ? SLOT_BITS : DIST_BITS;
	localparam int SUM_W  = 2 * DW + 4;
	localparam int DCNT_W = $clog2(SUM_W + 1);
	localparam int SEL_W  = $clog2(NUM_DIST);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [SEL_W-1:0]  cnt_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [2*DW-1:0]   prod_q;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  num_q;
	logic [TERM_W-1:0] rem_q;
	logic [BEST_W-1:0] lowest_q;
	logic [TAG_W-1:0]  lowest_tag_q;
	logic              res_valid_q;
	res_word_t         res_word_q;

	logic [SEL_W-1:0]   sel;
	logic [DW-1:0]      dsel;
	logic [TERM_W:0]    trial;
	logic               qbit;
	logic [TERM_W-1:0]  rem_n;
	logic [SCORE_W-1:0] score;
	logic               improved;
	logic [BEST_W-1:0]  best_n;
	logic [TAG_W-1:0]   best_tag_n;
	logic               out_free;

	assign sel  = (cnt_q < SEL_W'(NUM_DIST)) ? cnt_q : '0;
	assign dsel = job_q.used[sel] ? job_q.diff[sel][DW-1:0] : '0;

	// one restoring divide step per cycle, divisor is 5..11
	always_comb begin
		trial = {rem_q, num_q[SUM_W-1]};
		qbit  = (trial >= {1'b0, job_q.terms});
		rem_n = qbit ? TERM_W'(trial - {1'b0, job_q.terms}) : trial[TERM_W-1:0];
	end

	always_comb begin
		score      = SCORE_W'(num_q) + SCORE_W'(job_q.pen);
		improved   = (score < SCORE_W'(lowest_q));
		best_n     = improved ? score[BEST_W-1:0] : lowest_q;
		best_tag_n = improved ? job_q.tag : lowest_tag_q;
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = (state_q == ST_IDLE) && !empty;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			dcnt_q       <= '0;
			lowest_q     <= NO_BEST;
			lowest_tag_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			// in ST_FIN a free output register is refilled below
			if (res_valid_q && !res_stall && state_q != ST_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						job_q   <= head;
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// the squarer result is registered in prod_q and reaches the accumulator in the following cycle
					prod_q <= dsel * dsel;
					if (cnt_q != '0) begin
						acc_q <= acc_q + SUM_W'(prod_q);
					end
					if (cnt_q == SEL_W'(NUM_DIST)) begin
						num_q   <= acc_q + SUM_W'(prod_q);
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					num_q  <= {num_q[SUM_W-2:0], qbit};
					rem_q  <= rem_n;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q             <= 1'b1;
						res_word_q.record_score <= score;
						res_word_q.new_best     <= improved;
						res_word_q.best_score   <= best_n;
						res_word_q.best_tag     <= best_tag_n;
						res_word_q.search_done  <= job_q.last;
						if (job_q.last) begin
							lowest_q     <= NO_BEST;
							lowest_tag_q <= '0;
						end else begin
							lowest_q     <= best_n;
							lowest_tag_q <= best_tag_n;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/distance_vector_best_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The back end works on one word at a time with a shared squarer and a one-bit-per-cycle
// divider; it takes the next word from the queue only once the result word of the last one
// has been loaded into the output register.
// The front stage and a two-entry queue keep taking words while the back end works.
// Reset (arst_n low): query registers clear, penalty returns to 40, best score to 9999999,
// best tag to 0; the queue and the output register empty.

module distance_vector_best_match import dvbm_pkg::*; #(
	parameter int DIST_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// record channel
	input  wire logic              rec_valid,
	output logic                   rec_stall,
	input  wire rec_word_t         rec_word,
	// result channel
	output logic                   res_valid,
	input  wire logic              res_stall,
	output res_word_t              res_word,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic [1:0] reg_idx;

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic full;
	logic empty;

	// registers sit on 8-byte boundaries; low address bits are ignored
	assign reg_idx = paddr[4:3];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_near      <= '0;
			cfg_q.query_mid       <= '0;
			cfg_q.query_far       <= '0;
			cfg_q.residue_penalty <= PENALTY_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_QUERY_NEAR: cfg_q.query_near      <= pwdata;
				REG_QUERY_MID:  cfg_q.query_mid       <= pwdata;
				REG_QUERY_FAR:  cfg_q.query_far       <= pwdata[47:0];
				REG_PENALTY:    cfg_q.residue_penalty <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QUERY_NEAR: prdata = cfg_q.query_near;
			REG_QUERY_MID:  prdata = cfg_q.query_mid;
			REG_QUERY_FAR:  prdata = DATA_W'(cfg_q.query_far);
			REG_PENALTY:    prdata = DATA_W'(cfg_q.residue_penalty);
			default:        prdata = '0;
		endcase
	end

	// front: masks distances, forms |q - r|, term mask, term count and penalty
	dvbm_front #(
		.DIST_BITS(DIST_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec_word (rec_word),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	dvbm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	// back: sum of squares, divide by term count, add penalty, best-so-far tracking
	dvbm_back #(
		.DIST_BITS(DIST_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word)
	);

endmodule

`default_nettype wire
